>>> rtl/msa_pkg.sv
// shared types and constants for the multi-stack shared-array unit
package msa_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int CNT_W  = 4;
    localparam int NUM_IDX = 1 << IDX_W;
    localparam int NUM_CNT = 1 << CNT_W;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BADINDEX  = 2'd3;

    // result flags in the order they sit in the output tuser
    typedef struct packed {
        logic       is_empty;
        logic       is_full;
        logic [1:0] status;
    } t_meta;

endpackage

>>> rtl/multi_stack_shared_array_unit.sv
// several stacks in equal regions of one shared data memory
// results pass through the stage-1 and output registers; one push or pop per cycle
// unless output stalls; each item uses the single memory port at most once
// fill counts sit in flops, so a push followed by a pop needs no forwarding
// reset: one stack, all stacks empty, data memory left undefined (no clearing pass)
// a count register write empties every stack at once
module multi_stack_shared_array_unit
    import msa_pkg::*;
#(
    parameter int CAPACITY   = 128,
    parameter int MAX_STACKS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,       // num_stacks
    // command stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,   // value
    input  logic [3:0]        i_s_axis_tuser,   // cmd, stack_index[2:0]
    // result stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [DATA_W-1:0] o_m_axis_tdata,   // data
    output logic [3:0]        o_m_axis_tuser    // status[1:0], is_full, is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RW = $clog2(CAPACITY + 1);
    localparam int BW = IDX_W + RW;

    // region size and effective stack count for every register code
    logic [RW-1:0]    w_region_tab [NUM_CNT];
    logic [CNT_W-1:0] w_count_tab  [NUM_CNT];

    for (genvar g = 0; g < NUM_CNT; g++) begin : g_tab
        localparam int Eff = (g == 0) ? 1 : ((g > MAX_STACKS) ? MAX_STACKS : g);
        localparam int Reg = CAPACITY / Eff;
        assign w_region_tab[g] = RW'(Reg);
        assign w_count_tab[g]  = CNT_W'(Eff);
    end

    logic [CNT_W-1:0] r_count;
    logic [RW-1:0]    r_region;
    logic [RW-1:0]    r_fill [NUM_IDX];

    logic          r_s1_vld;
    logic          r_s1_rd;
    t_meta         r_s1_meta;
    logic          r_o_vld;
    logic [DATA_W-1:0] r_o_data;
    t_meta         r_o_meta;

    logic          w_acc;
    logic          w_s1_move;
    logic          w_cmd;
    logic [IDX_W-1:0] w_idx;
    logic [RW-1:0] w_fill;
    logic          w_valid_idx;
    logic          w_ovf;
    logic          w_unf;
    logic [RW-1:0] n_fill;
    logic [BW-1:0] w_base;
    logic [AW-1:0] w_addr;
    logic          w_we;
    logic          w_re;
    t_meta         n_meta;
    logic [DATA_W-1:0] w_rdata;

    assign w_cmd = i_s_axis_tuser[0];
    assign w_idx = i_s_axis_tuser[3:1];

    assign w_s1_move       = r_s1_vld && (!r_o_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_vld || w_s1_move;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_comb begin
        w_fill      = r_fill[w_idx];
        w_valid_idx = {1'b0, w_idx} < r_count;
        w_ovf       = (w_cmd == CMD_PUSH) && (w_fill >= r_region);
        w_unf       = (w_cmd == CMD_POP) && (w_fill == '0);
        n_fill      = w_fill;
        if (w_valid_idx && !w_ovf && !w_unf) begin
            n_fill = (w_cmd == CMD_PUSH) ? w_fill + RW'(1) : w_fill - RW'(1);
        end
        w_base = BW'(w_idx) * BW'(r_region);
        // push writes at the old top, pop reads the new top
        w_addr = w_base[AW-1:0] + ((w_cmd == CMD_PUSH) ? w_fill[AW-1:0] : n_fill[AW-1:0]);
        w_we   = w_acc && w_valid_idx && (w_cmd == CMD_PUSH) && !w_ovf;
        w_re   = w_acc && w_valid_idx && (w_cmd == CMD_POP) && !w_unf;

        n_meta.status   = ST_OK;
        n_meta.is_full  = 1'b0;
        n_meta.is_empty = 1'b0;
        if (!w_valid_idx) begin
            n_meta.status = ST_BADINDEX;
        end else begin
            if (w_ovf) begin
                n_meta.status = ST_OVERFLOW;
            end else if (w_unf) begin
                n_meta.status = ST_UNDERFLOW;
            end
            n_meta.is_full  = n_fill >= r_region;
            n_meta.is_empty = n_fill == '0;
        end
    end

    msa_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (i_s_axis_tdata),
        .o_rdata (w_rdata)
    );

    // configuration and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= CNT_W'(1);
            r_region <= RW'(CAPACITY);
            for (int k = 0; k < NUM_IDX; k++) begin
                r_fill[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            r_count  <= w_count_tab[i_cfg_data];
            r_region <= w_region_tab[i_cfg_data];
            for (int k = 0; k < NUM_IDX; k++) begin
                r_fill[k] <= '0;
            end
        end else if (w_acc && w_valid_idx) begin
            r_fill[w_idx] <= n_fill;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_move) begin
                r_o_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_rd   <= w_re;
            r_s1_meta <= n_meta;
        end
        if (w_s1_move) begin
            r_o_data <= r_s1_rd ? w_rdata : '1;
            r_o_meta <= r_s1_meta;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_meta;

endmodule

>>> rtl/msa_store.sv
// single-port data memory with registered read data
module msa_store
    import msa_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [AW-1:0]     i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
